/* hdl/matrix_multiply_4x4_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply unit
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MM4_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

`define MM4_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`else

`define MM4_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define MM4_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hdl/mm4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply package
// Sizes, types and the output saturation function of the matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM         = 4;
    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int CELLS  = DIM * DIM;
    localparam int DIM_W  = $clog2(DIM);
    localparam int IDX_W  = $clog2(CELLS);
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
    localparam int TOP_W  = ACC_W - VALUE_WIDTH + 1;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [DIM_W-1:0]              dim_idx_t;
    typedef logic [IDX_W-1:0]              cell_idx_t;

    typedef struct packed {
        dim_idx_t row;
        dim_idx_t col;
        logic     first;
        logic     last;
    } tag_t;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    function automatic value_t saturate(input acc_t sum);
        acc_t             shifted;
        logic [TOP_W-1:0] top;
        value_t           res;
        shifted = sum >>> FRAC_BITS;
        top     = shifted[ACC_W-1:VALUE_WIDTH-1];
        if ((&top) || !(|top)) begin
            res = shifted[VALUE_WIDTH-1:0];
        end else if (shifted[ACC_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

endpackage

/* hdl/matrix_multiply_4x4_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply unit, C = A * B
// Loads A and B as sixteen requests and streams out the sixteen elements of C.
// ----------------------------------------------------------------------------
// Each input request writes one element of A and of B into two 16-entry
// memories, one request per cycle during the load phase. The sixteenth
// request starts the product phase: one multiply-accumulate unit reads one A
// and one B element per cycle unless the output stalls, and each element of
// C sums four products. The next pair of matrices may start loading as soon
// as the last reads are issued. Each result passes through the read, product,
// accumulator and output registers. Results are Q16.16, truncated toward
// minus infinity and saturated to 32 bits.
`include "matrix_multiply_4x4_unit_defines.svh"

module matrix_multiply_4x4_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mm4_pkg::value_t           s_a_value,
    input  mm4_pkg::value_t           s_b_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mm4_pkg::value_t           m_c_value,
    output logic [mm4_pkg::DIM_W-1:0] m_c_row,
    output logic [mm4_pkg::DIM_W-1:0] m_c_col,
    output logic                      m_last_element
);
    import mm4_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_CALC = 1'b1;

    localparam dim_idx_t  DIM_LAST  = DIM_W'(DIM - 1);
    localparam cell_idx_t CELL_LAST = IDX_W'(CELLS - 1);

    value_t a_mem [CELLS];
    value_t b_mem [CELLS];

    logic      state_reg, state_next;
    cell_idx_t load_cnt_reg, load_cnt_next;
    dim_idx_t  row_reg, row_next;
    dim_idx_t  col_reg, col_next;
    dim_idx_t  k_reg, k_next;

    logic   rd_valid_reg;
    tag_t   rd_tag_reg;
    value_t a_rd_reg;
    value_t b_rd_reg;

    logic  prod_valid_reg;
    tag_t  prod_tag_reg;
    prod_t prod_reg;

    logic acc_done_reg;
    tag_t acc_tag_reg;
    acc_t acc_reg;

    logic     m_valid_reg;
    value_t   m_value_reg;
    dim_idx_t m_row_reg;
    dim_idx_t m_col_reg;
    logic     m_last_reg;

    logic      adv;
    logic      load_acc;
    logic      issue;
    cell_idx_t a_addr;
    cell_idx_t b_addr;
    tag_t      issue_tag;

    assign adv      = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_LOAD);
    assign load_acc = s_valid && s_ready;
    assign issue    = (state_reg == ST_CALC) && adv;

    assign a_addr = IDX_W'(32'(row_reg) * DIM + 32'(k_reg));
    assign b_addr = IDX_W'(32'(k_reg) * DIM + 32'(col_reg));

    always_comb begin
        issue_tag.row   = row_reg;
        issue_tag.col   = col_reg;
        issue_tag.first = (k_reg == '0);
        issue_tag.last  = (k_reg == DIM_LAST);
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        case (state_reg)
            ST_LOAD: begin
                if (load_acc) begin
                    if (load_cnt_reg == CELL_LAST) begin
                        load_cnt_next = '0;
                        state_next    = ST_CALC;
                    end else begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (issue) begin
                    if (k_reg == DIM_LAST) begin
                        k_next = '0;
                        if (col_reg == DIM_LAST) begin
                            col_next = '0;
                            if (row_reg == DIM_LAST) begin
                                row_next   = '0;
                                state_next = ST_LOAD;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            a_mem[load_cnt_reg] <= s_a_value;
            b_mem[load_cnt_reg] <= s_b_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            a_rd_reg   <= a_mem[a_addr];
            b_rd_reg   <= b_mem[b_addr];
            rd_tag_reg <= issue_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg     <= PROD_W'(a_rd_reg) * PROD_W'(b_rd_reg);
            prod_tag_reg <= rd_tag_reg;
            if (prod_valid_reg) begin
                acc_reg <= prod_tag_reg.first ? ACC_W'(prod_reg)
                                              : acc_reg + ACC_W'(prod_reg);
            end
            acc_tag_reg <= prod_tag_reg;
            if (acc_done_reg) begin
                m_value_reg <= saturate(acc_reg);
                m_row_reg   <= acc_tag_reg.row;
                m_col_reg   <= acc_tag_reg.col;
                m_last_reg  <= (acc_tag_reg.row == DIM_LAST) &&
                               (acc_tag_reg.col == DIM_LAST);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_done_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (adv) begin
            rd_valid_reg   <= (state_reg == ST_CALC);
            prod_valid_reg <= rd_valid_reg;
            acc_done_reg   <= prod_valid_reg && prod_tag_reg.last;
            m_valid_reg    <= acc_done_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_c_value      = m_value_reg;
    assign m_c_row        = m_row_reg;
    assign m_c_col        = m_col_reg;
    assign m_last_element = m_last_reg;

    `MM4_ASSERT_NEXT(p_sum_kept_on_stall, aclk, aresetn, acc_done_reg && m_valid_reg && !m_ready, acc_done_reg && $stable(acc_reg))
    `MM4_ASSERT_NEXT(p_load_starts_calc, aclk, aresetn, load_acc && (load_cnt_reg == CELL_LAST), (state_reg == ST_CALC) && (k_reg == '0) && (row_reg == '0))
    `MM4_ASSERT_IMPL(p_count_idle_in_calc, aclk, aresetn, state_reg == ST_CALC, (load_cnt_reg == '0) && !s_ready)
    `MM4_ASSERT_NEXT(p_issue_frozen, aclk, aresetn, (state_reg == ST_CALC) && m_valid_reg && !m_ready, $stable(k_reg) && $stable(col_reg) && $stable(row_reg))

endmodule
